[rtl/bpt_pkg.sv]
package bpt_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int HELD_W      = $clog2(TABLE_DEPTH + 1);
    localparam int COUNT_W     = 5;
    localparam int VALUE_W     = 32;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_DELETE = 2'd1,
        OP_SEARCH = 2'd2
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_LAST_KEPT = 2'd3
    } status_t;

    typedef struct packed {
        logic                      vld;
        logic [IDX_W-1:0]          idx;
        logic                      slot_vld;
        logic signed [VALUE_W-1:0] data;
    } scan_elem_t;

    typedef struct packed {
        logic                      any;
        logic signed [VALUE_W-1:0] hi;
        logic signed [VALUE_W-1:0] lo;
        logic                      match_found;
        logic [IDX_W-1:0]          match_idx;
        logic                      free_found;
        logic [IDX_W-1:0]          free_idx;
    } scan_acc_t;

endpackage

[rtl/bpt_scan_unit.sv]
module bpt_scan_unit (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               clear,
    input  logic                               skip_first,
    input  logic signed [bpt_pkg::VALUE_W-1:0] key,
    input  bpt_pkg::scan_elem_t                elem,
    output bpt_pkg::scan_acc_t                 acc
);

    bpt_pkg::scan_acc_t acc_reg;
    bpt_pkg::scan_acc_t acc_next;

    logic hit;
    logic take;

    // One slot per cycle while elem.vld is high: the first matching slot is skipped from the extremes
    // when a delete is going to remove it.
    always_comb
    begin
        acc_next = acc_reg;
        hit      = elem.slot_vld && (elem.data == key);
        take     = elem.slot_vld && !(hit && !acc_reg.match_found && skip_first);
        if (hit && !acc_reg.match_found)
        begin
            acc_next.match_found = 1'b1;
            acc_next.match_idx   = elem.idx;
        end
        if (!elem.slot_vld && !acc_reg.free_found)
        begin
            acc_next.free_found = 1'b1;
            acc_next.free_idx   = elem.idx;
        end
        if (take)
        begin
            if (!acc_reg.any)
            begin
                acc_next.any = 1'b1;
                acc_next.hi  = elem.data;
                acc_next.lo  = elem.data;
            end
            else
            begin
                if (elem.data > acc_reg.hi)
                begin
                    acc_next.hi = elem.data;
                end
                if (elem.data < acc_reg.lo)
                begin
                    acc_next.lo = elem.data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else if (clear)
        begin
            acc_reg <= '0;
        end
        else if (elem.vld)
        begin
            acc_reg <= acc_next;
        end
    end

    assign acc = acc_reg;

endmodule

[rtl/bag_priority_table.sv]
// Channel   Ports                                        Handshake
// command   opcode, item_value                           start high while busy low
// result    status, max_value, min_value, entry_count    done high for one cycle
//
// Each word runs through the slot scan, which reads one slot of the value memory
// per cycle, then through a drain state for the read and a commit state.
// A new word can be accepted in the cycle that shows the previous result.
// The receiver cannot hold a result off, so done is never stretched.
// Reset clears all valid bits and the count at once; no clearing pass is needed.
module bag_priority_table (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [1:0]                         opcode,
    input  logic signed [bpt_pkg::VALUE_W-1:0] item_value,
    output logic                               done,
    output logic [1:0]                         status,
    output logic signed [bpt_pkg::VALUE_W-1:0] max_value,
    output logic signed [bpt_pkg::VALUE_W-1:0] min_value,
    output logic [bpt_pkg::COUNT_W-1:0]        entry_count
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_COMMIT
    } state_t;

    localparam logic [bpt_pkg::IDX_W-1:0] LAST_IDX = bpt_pkg::IDX_W'(bpt_pkg::TABLE_DEPTH - 1);

    state_t                               state_reg;
    logic [1:0]                           op_reg;
    logic signed [bpt_pkg::VALUE_W-1:0]   value_reg;
    logic [bpt_pkg::IDX_W-1:0]            scan_idx_reg;
    logic [bpt_pkg::TABLE_DEPTH-1:0]      valid_reg;
    logic [bpt_pkg::HELD_W-1:0]           held_reg;
    logic                                 done_reg;
    logic [1:0]                           status_reg;
    logic signed [bpt_pkg::VALUE_W-1:0]   max_reg;
    logic signed [bpt_pkg::VALUE_W-1:0]   min_reg;

    logic signed [bpt_pkg::VALUE_W-1:0]   slot_mem [bpt_pkg::TABLE_DEPTH];
    logic signed [bpt_pkg::VALUE_W-1:0]   rd_data_reg;
    logic [bpt_pkg::IDX_W-1:0]            p_idx_reg;
    logic                                 p_vld_reg;

    logic                                 accept;
    logic                                 skip_first;
    bpt_pkg::scan_elem_t                  elem;
    bpt_pkg::scan_acc_t                   acc;

    logic [1:0]                           status_next;
    logic signed [bpt_pkg::VALUE_W-1:0]   max_next;
    logic signed [bpt_pkg::VALUE_W-1:0]   min_next;
    logic [bpt_pkg::TABLE_DEPTH-1:0]      valid_next;
    logic [bpt_pkg::HELD_W-1:0]           held_next;
    logic                                 wr_en;

    assign accept     = start && (state_reg == S_IDLE);
    assign skip_first = (op_reg == bpt_pkg::OP_DELETE) && (held_reg != bpt_pkg::HELD_W'(1));

    assign elem.vld      = p_vld_reg;
    assign elem.idx      = p_idx_reg;
    assign elem.slot_vld = valid_reg[p_idx_reg];
    assign elem.data     = rd_data_reg;

    bpt_scan_unit u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear      (accept),
        .skip_first (skip_first),
        .key        (value_reg),
        .elem       (elem),
        .acc        (acc)
    );

    always_comb
    begin
        status_next = bpt_pkg::ST_NOT_FOUND;
        max_next    = acc.any ? acc.hi : '0;
        min_next    = acc.any ? acc.lo : '0;
        valid_next  = valid_reg;
        held_next   = held_reg;
        wr_en       = 1'b0;
        case (op_reg)
            bpt_pkg::OP_INSERT:
            begin
                if (acc.free_found)
                begin
                    status_next               = bpt_pkg::ST_OK;
                    valid_next[acc.free_idx]  = 1'b1;
                    held_next                 = held_reg + bpt_pkg::HELD_W'(1);
                    wr_en                     = 1'b1;
                    if (!acc.any || value_reg > acc.hi)
                    begin
                        max_next = value_reg;
                    end
                    if (!acc.any || value_reg < acc.lo)
                    begin
                        min_next = value_reg;
                    end
                end
                else
                begin
                    status_next = bpt_pkg::ST_FULL;
                end
            end
            bpt_pkg::OP_DELETE:
            begin
                if (held_reg == bpt_pkg::HELD_W'(1))
                begin
                    status_next = bpt_pkg::ST_LAST_KEPT;
                end
                else if (acc.match_found)
                begin
                    status_next               = bpt_pkg::ST_OK;
                    valid_next[acc.match_idx] = 1'b0;
                    held_next                 = held_reg - bpt_pkg::HELD_W'(1);
                end
            end
            bpt_pkg::OP_SEARCH:
            begin
                if (acc.match_found)
                begin
                    status_next = bpt_pkg::ST_OK;
                end
            end
            default:
            begin
                status_next = bpt_pkg::ST_NOT_FOUND;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_COMMIT && wr_en)
        begin
            slot_mem[acc.free_idx] <= value_reg;
        end
        rd_data_reg <= slot_mem[scan_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= '0;
            value_reg    <= '0;
            scan_idx_reg <= '0;
            valid_reg    <= '0;
            held_reg     <= '0;
            p_idx_reg    <= '0;
            p_vld_reg    <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= '0;
            max_reg      <= '0;
            min_reg      <= '0;
        end
        else
        begin
            done_reg  <= (state_reg == S_COMMIT);
            p_vld_reg <= (state_reg == S_SCAN);
            p_idx_reg <= scan_idx_reg;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        op_reg       <= opcode;
                        value_reg    <= item_value;
                        scan_idx_reg <= '0;
                        state_reg    <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (scan_idx_reg == LAST_IDX)
                    begin
                        state_reg <= S_DRAIN;
                    end
                    else
                    begin
                        scan_idx_reg <= scan_idx_reg + bpt_pkg::IDX_W'(1);
                    end
                end
                S_DRAIN:
                begin
                    state_reg <= S_COMMIT;
                end
                S_COMMIT:
                begin
                    valid_reg  <= valid_next;
                    held_reg   <= held_next;
                    status_reg <= status_next;
                    max_reg    <= max_next;
                    min_reg    <= min_next;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy        = (state_reg != S_IDLE);
    assign done        = done_reg;
    assign status      = status_reg;
    assign max_value   = max_reg;
    assign min_value   = min_reg;
    assign entry_count = bpt_pkg::COUNT_W'(held_reg);

endmodule

[rtl/bpt_checker.sv]
module bpt_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        done,
    input logic [1:0]                  status,
    input logic [bpt_pkg::COUNT_W-1:0] entry_count
);

    // A result is shown only while the block is free for the next word.
    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted word did not raise busy");

    // Every finished word produces its result as busy drops.
    a_fall_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("operation ended without a result");

    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == bpt_pkg::ST_FULL) |->
            (entry_count == bpt_pkg::COUNT_W'(bpt_pkg::TABLE_DEPTH)))
        else $error("table full reported with free slots");

endmodule

bind bag_priority_table bpt_checker u_bpt_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .entry_count (entry_count)
);

[verif/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;

    import bpt_pkg::*;

    localparam logic [1:0]                OP_UNUSED = 2'd3;
    localparam logic signed [VALUE_W-1:0] V_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] V_MIN     = 32'sh8000_0000;
    localparam int                        POOL_SIZE = 6;
    localparam int                        N_PHASES  = 7;
    localparam int                        PHASE_LEN = 250;

    typedef struct {
        status_t                   st;
        logic signed [VALUE_W-1:0] hi;
        logic signed [VALUE_W-1:0] lo;
        logic [COUNT_W-1:0]        cnt;
    } bag_result_t;

    // Holds a private copy of the bag and the queue of results still owed.
    class bag_scoreboard;
        logic signed [VALUE_W-1:0] slot_val [TABLE_DEPTH];
        bit                        slot_used [TABLE_DEPTH];
        int unsigned               held;
        bag_result_t               expected_q [$];
        int unsigned               n_errors;

        function int lowest_match(logic signed [VALUE_W-1:0] v);
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (slot_used[i] && slot_val[i] == v)
                    return i;
            end
            return -1;
        endfunction

        function void note_word(logic [1:0] op, logic signed [VALUE_W-1:0] v);
            bag_result_t r;
            int          idx;
            bit          any;
            r.st = ST_NOT_FOUND;
            case (op)
                OP_INSERT:
                begin
                    idx = -1;
                    for (int i = TABLE_DEPTH - 1; i >= 0; i--)
                    begin
                        if (!slot_used[i])
                            idx = i;
                    end
                    if (idx < 0)
                        r.st = ST_FULL;
                    else
                    begin
                        slot_val[idx]  = v;
                        slot_used[idx] = 1'b1;
                        held++;
                        r.st = ST_OK;
                    end
                end
                OP_DELETE:
                begin
                    if (held == 1)
                        r.st = ST_LAST_KEPT;
                    else
                    begin
                        idx = lowest_match(v);
                        if (idx >= 0)
                        begin
                            slot_used[idx] = 1'b0;
                            held--;
                            r.st = ST_OK;
                        end
                    end
                end
                OP_SEARCH:
                begin
                    if (lowest_match(v) >= 0)
                        r.st = ST_OK;
                end
                default:
                    ;
            endcase
            any  = 1'b0;
            r.hi = '0;
            r.lo = '0;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (slot_used[i])
                begin
                    if (!any || slot_val[i] > r.hi)
                        r.hi = slot_val[i];
                    if (!any || slot_val[i] < r.lo)
                        r.lo = slot_val[i];
                    any = 1'b1;
                end
            end
            r.cnt = COUNT_W'(held);
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [1:0] st, logic signed [VALUE_W-1:0] hi,
                                   logic signed [VALUE_W-1:0] lo, logic [COUNT_W-1:0] cnt);
            bag_result_t r;
            if (expected_q.size() == 0)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: status %0d max %0d min %0d count %0d",
                             st, hi, lo, cnt);
                return;
            end
            r = expected_q.pop_front();
            if (st !== r.st || hi !== r.hi || lo !== r.lo || cnt !== r.cnt)
            begin
                n_errors++;
                if (n_errors <= 10)
                    $display("mismatch: status %0d/%0d max %0d/%0d min %0d/%0d count %0d/%0d",
                             r.st, st, r.hi, hi, r.lo, lo, r.cnt, cnt);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic signed [VALUE_W-1:0] any_held();
            int k;
            k = $urandom_range(0, held - 1);
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (slot_used[i])
                begin
                    if (k == 0)
                        return slot_val[i];
                    k--;
                end
            end
            return '0;
        endfunction
    endclass

    logic                        clk = 1'b0;
    logic                        rst_n;
    logic                        start;
    logic                        busy;
    logic [1:0]                  opcode;
    logic signed [VALUE_W-1:0]   item_value;
    logic                        done;
    logic [1:0]                  status;
    logic signed [VALUE_W-1:0]   max_value;
    logic signed [VALUE_W-1:0]   min_value;
    logic [COUNT_W-1:0]          entry_count;

    bag_scoreboard               sb = new();
    logic signed [VALUE_W-1:0]   pool [POOL_SIZE];

    bag_priority_table dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .opcode      (opcode),
        .item_value  (item_value),
        .done        (done),
        .status      (status),
        .max_value   (max_value),
        .min_value   (min_value),
        .entry_count (entry_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(status, max_value, min_value, entry_count);
    end

    task automatic send_word(input logic [1:0] op, input logic signed [VALUE_W-1:0] v,
                             input int idle_pct);
        if ($urandom_range(0, 99) < idle_pct)
        begin
            @(negedge clk);
            start      = 1'b0;
            opcode     = 2'($urandom);
            item_value = $urandom;
            repeat ($urandom_range(0, 24)) @(negedge clk);
        end
        @(negedge clk);
        start      = 1'b1;
        opcode     = op;
        item_value = v;
        do @(posedge clk); while (busy);
        sb.note_word(op, v);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        start = 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
    endtask

    function automatic logic signed [VALUE_W-1:0] next_value(bit prefer_held);
        int r;
        r = $urandom_range(0, 99);
        if (prefer_held && sb.held > 0 && r < 60)
            return sb.any_held();
        if (r < 75)
            return pool[$urandom_range(0, POOL_SIZE - 1)];
        if (r < 85)
        begin
            case ($urandom_range(0, 3))
                0: return V_MIN;
                1: return V_MAX;
                2: return '0;
                default: return -1;
            endcase
        end
        return $urandom;
    endfunction

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int                        idle_pct;
        int                        run_left;
        int                        r;
        bit                        filling;
        logic [1:0]                op;
        logic signed [VALUE_W-1:0] v;

        rst_n      = 1'b0;
        start      = 1'b0;
        opcode     = OP_INSERT;
        item_value = '0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        send_word(OP_SEARCH, 32'sd1, 0);
        send_word(OP_DELETE, 32'sd1, 0);
        send_word(OP_UNUSED, V_MAX, 0);
        send_word(OP_INSERT, V_MAX, 0);
        send_word(OP_DELETE, V_MIN, 0);
        send_word(OP_DELETE, V_MAX, 0);
        send_word(OP_INSERT, V_MIN, 0);
        send_word(OP_INSERT, V_MIN, 0);
        send_word(OP_DELETE, V_MIN, 0);
        send_word(OP_SEARCH, V_MIN, 0);
        send_word(OP_DELETE, 32'sd7, 0);
        send_word(OP_UNUSED, V_MIN, 0);
        for (int i = 0; i < TABLE_DEPTH - 2; i++)
            send_word(OP_INSERT, (i == 0) ? '0 : (i == 1) ? -1 : $urandom, 0);
        send_word(OP_INSERT, 32'sd5, 0);
        send_word(OP_SEARCH, 32'sd123, 0);
        wait_drained();

        filling  = 1'b0;
        run_left = 0;
        for (int p = 0; p < N_PHASES; p++)
        begin
            idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 62 : 13;
            for (int k = 0; k < POOL_SIZE; k++)
                pool[k] = $urandom_range(0, 1) ? VALUE_W'($urandom_range(0, 15)) - 8
                                               : VALUE_W'($urandom);
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if (run_left == 0)
                begin
                    filling  = ~filling;
                    run_left = $urandom_range(20, 60);
                end
                run_left--;
                r = $urandom_range(0, 99);
                if (r < 5)
                    op = OP_UNUSED;
                else if (r < 20)
                    op = OP_SEARCH;
                else if (r < 60)
                    op = filling ? OP_INSERT : OP_DELETE;
                else if (r < 80)
                    op = filling ? OP_DELETE : OP_INSERT;
                else
                    op = filling ? OP_INSERT : OP_DELETE;
                v = next_value(op != OP_INSERT && $urandom_range(0, 1));
                send_word(op, v, idle_pct);
            end
            wait_drained();
        end

        repeat (TABLE_DEPTH + 4) @(posedge clk);
        if (sb.n_errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/bpt_pkg.sv
rtl/bpt_scan_unit.sv
rtl/bag_priority_table.sv
rtl/bpt_checker.sv
verif/tb_top.sv
